// ===== hdl/rpn_stack_evaluator_top_defines.svh =====
// Assertion macros used by the stack evaluator top level.
// No dependencies; expects i_clk and i_rst_n in the including module.
`ifndef RPN_STACK_EVALUATOR_TOP_DEFINES_SVH
`define RPN_STACK_EVALUATOR_TOP_DEFINES_SVH

// property checked on every clock edge outside reset
`define STEV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// consequence checked in the cycle after the antecedent
`define STEV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/stev_pkg.sv =====
// Types and constants of the stack evaluator.
// No dependencies.
package stev_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int DATA_W          = 32;
    localparam int CHAR_W          = 8;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_MUL   = 8'd42;
    localparam logic [CHAR_W-1:0] CHAR_DIV   = 8'd47;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;

    typedef enum logic [2:0] {
        ST_PENDING  = 3'd0,
        ST_OK       = 3'd1,
        ST_ILLEGAL  = 3'd2,
        ST_FEW      = 3'd3,
        ST_DIVZERO  = 3'd4,
        ST_COUNT    = 3'd5,
        ST_OVERFLOW = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_LOAD = 2'd1,
        CELL_PULL = 2'd2
    } t_cell_op;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        t_status                  status;
        logic                     done_res;
    } t_out_word;

endpackage

// ===== hdl/rpn_stack_evaluator_top.sv =====
// Stack evaluator top level: decode, stack cell chain, divider, result register.
// Depends on stev_pkg, stev_cell, stev_div and rpn_stack_evaluator_top_defines.svh.
//
// One ASCII character is taken per word and one result word is returned for every
// character; only the word marked last carries a final status and value. A digit,
// space, + - * or illegal character commits in the cycle it is taken; a / that
// reaches the divider goes through the start, 32 steps of the one-bit-per-cycle
// restoring divider, and the commit. A new character is taken once the previous
// result word has left or leaves in the same cycle. The stack is a chain of STACK_DEPTH
// cells with the top entry in cell 0; a push shifts the chain down and an operator
// pulls it up, so entries need no clearing after reset or after the last character.
module rpn_stack_evaluator_top #(
    parameter int STACK_DEPTH = stev_pkg::STACK_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  stev_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output stev_pkg::t_out_word o_out_word
);
    import stev_pkg::*;

`include "rpn_stack_evaluator_top_defines.svh"

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DIV  = 2'b10
    } t_state;

    t_state          r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    t_status         r_err, n_err;
    logic            r_last;
    logic            r_out_valid;
    t_out_word       r_out_word;

    logic [DATA_W-1:0] w_cell [STACK_DEPTH];
    t_cell_op          cell_op [STACK_DEPTH];

    logic              accept;
    logic              is_digit, is_op, is_space;
    logic              push_en, merge_en, start_div, commit, last_now;
    logic [DATA_W-1:0] load_val, alu_val, next_top;
    logic              div_done;
    logic [DATA_W-1:0] div_quot;
    t_out_word         n_out_word;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        is_digit = (i_in_word.char_code >= CHAR_ZERO) && (i_in_word.char_code <= CHAR_NINE);
        is_op    = (i_in_word.char_code == CHAR_PLUS) || (i_in_word.char_code == CHAR_MINUS)
                || (i_in_word.char_code == CHAR_MUL) || (i_in_word.char_code == CHAR_DIV);
        is_space = (i_in_word.char_code == CHAR_SPACE);
    end

    always_comb begin
        unique case (i_in_word.char_code)
            CHAR_PLUS:  alu_val = w_cell[1] + w_cell[0];
            CHAR_MINUS: alu_val = w_cell[1] - w_cell[0];
            default:    alu_val = w_cell[1] * w_cell[0];
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_err     = r_err;
        push_en   = 1'b0;
        merge_en  = 1'b0;
        start_div = 1'b0;
        commit    = 1'b0;
        load_val  = alu_val;
        last_now  = r_last;
        unique case (r_state)
            S_IDLE: begin
                last_now = i_in_word.last;
                if (accept) begin
                    commit = 1'b1;
                    if (!is_digit && !is_op && !is_space) begin
                        n_err = ST_ILLEGAL;
                    end else if (r_err != ST_PENDING || is_space) begin
                        n_err = r_err;
                    end else if (is_digit) begin
                        if (r_count == CNT_W'(STACK_DEPTH)) begin
                            n_err = ST_OVERFLOW;
                        end else begin
                            // low nibble of '0'..'9' is the digit value
                            load_val = DATA_W'(i_in_word.char_code[3:0]);
                            push_en  = 1'b1;
                            n_count  = r_count + 1'b1;
                        end
                    end else if (r_count < CNT_W'(2)) begin
                        n_err = ST_FEW;
                    end else if (i_in_word.char_code == CHAR_DIV) begin
                        if (w_cell[0] == '0) begin
                            n_err = ST_DIVZERO;
                        end else begin
                            start_div = 1'b1;
                            commit    = 1'b0;
                            n_state   = S_DIV;
                        end
                    end else begin
                        merge_en = 1'b1;
                        n_count  = r_count - 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    commit   = 1'b1;
                    load_val = div_quot;
                    merge_en = 1'b1;
                    n_count  = r_count - 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        next_top = (push_en || merge_en) ? load_val : w_cell[0];
        n_out_word = '{value: '0, status: ST_PENDING, done_res: 1'b0};
        if (commit && last_now) begin
            n_out_word.done_res = 1'b1;
            if (n_err != ST_PENDING) begin
                n_out_word.status = n_err;
            end else if (n_count != CNT_W'(1)) begin
                n_out_word.status = ST_COUNT;
            end else begin
                n_out_word.status = ST_OK;
                n_out_word.value  = next_top;
            end
            n_count = '0;
            n_err   = ST_PENDING;
        end
    end

    always_comb begin
        for (int i = 0; i < STACK_DEPTH; i++) begin
            if (push_en || (merge_en && i == 0)) begin
                cell_op[i] = CELL_LOAD;
            end else if (merge_en) begin
                cell_op[i] = CELL_PULL;
            end else begin
                cell_op[i] = CELL_HOLD;
            end
        end
    end

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] w_above, w_below;
        assign w_above = (g == 0) ? load_val : w_cell[(g == 0) ? 0 : g - 1];
        assign w_below = (g == STACK_DEPTH - 1) ? '0
                       : w_cell[(g == STACK_DEPTH - 1) ? g : g + 1];
        stev_cell u_cell (
            .i_clk        (i_clk),
            .i_op         (cell_op[g]),
            .i_from_above (w_above),
            .i_from_below (w_below),
            .o_val        (w_cell[g])
        );
    end

    stev_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start_div),
        .i_dividend (w_cell[1]),
        .i_divisor  (w_cell[0]),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_err       <= ST_PENDING;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_err   <= n_err;
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_last <= i_in_word.last;
        end
        if (commit) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `STEV_ASSERT(a_count_range, r_count <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
    `STEV_ASSERT_NEXT(a_clear_on_last, commit && last_now,
        r_count == '0 && r_err == ST_PENDING, "state not cleared after last word")
    `STEV_ASSERT_NEXT(a_div_blocks, start_div, r_state == S_DIV && !o_in_ready,
        "input taken during division")
    `STEV_ASSERT(a_value_only_ok,
        !(o_out_valid && o_out_word.status != ST_OK) || o_out_word.value == '0,
        "nonzero value without ok status")

endmodule

// ===== hdl/stev_cell.sv =====
// One stack entry; loads from the cell above or pulls from the cell below.
// Depends on stev_pkg.
module stev_cell (
    input  logic                         i_clk,
    input  stev_pkg::t_cell_op           i_op,
    input  logic [stev_pkg::DATA_W-1:0]  i_from_above,
    input  logic [stev_pkg::DATA_W-1:0]  i_from_below,
    output logic [stev_pkg::DATA_W-1:0]  o_val
);
    import stev_pkg::*;

    logic [DATA_W-1:0] r_val;

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            CELL_LOAD: r_val <= i_from_above;
            CELL_PULL: r_val <= i_from_below;
            default:   r_val <= r_val;
        endcase
    end

    assign o_val = r_val;

endmodule

// ===== hdl/stev_div.sv =====
// Signed 32-bit divider, restoring, one quotient bit per cycle, truncating.
// Depends on stev_pkg.
module stev_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [stev_pkg::DATA_W-1:0]  i_dividend,
    input  logic [stev_pkg::DATA_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic [stev_pkg::DATA_W-1:0]  o_quot
);
    import stev_pkg::*;

    localparam int STEP_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_den;
    logic              r_neg;
    logic [DATA_W-1:0] r_quot;

    logic [DATA_W:0]   rem_shift;
    logic [DATA_W:0]   diff;
    logic [DATA_W-1:0] n_rem;
    logic [DATA_W-1:0] n_quo;

    always_comb begin
        rem_shift = {r_rem, r_quo[DATA_W-1]};
        diff      = rem_shift - {1'b0, r_den};
        if (!diff[DATA_W]) begin
            n_rem = diff[DATA_W-1:0];
            n_quo = {r_quo[DATA_W-2:0], 1'b1};
        end else begin
            n_rem = rem_shift[DATA_W-1:0];
            n_quo = {r_quo[DATA_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend[DATA_W-1] ? -i_dividend : i_dividend;
            r_den <= i_divisor[DATA_W-1] ? -i_divisor : i_divisor;
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            if (r_step == STEP_W'(DATA_W - 1)) begin
                r_quot <= r_neg ? -n_quo : n_quo;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
